@@ design/rdsst_pkg.sv @@
package rdsst_pkg;

    localparam int PHASE_COUNT  = 16;
    localparam int WINDOW_DEPTH = 256;

    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 16;
    localparam int PHASE_W   = $clog2(PHASE_COUNT);
    localparam int PTR_W     = $clog2(WINDOW_DEPTH);
    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W     = MAG_W + PTR_W;
    localparam int PROD_W    = SUM_W + CNT_W;
    localparam int SCAN_W    = $clog2(PHASE_COUNT + 1);
    localparam int EVT_W     = 8;
    localparam int HIST_AW   = PHASE_W + PTR_W;
    localparam int HIST_DEPTH = PHASE_COUNT << PTR_W;

    localparam int EVT_MAX   = 255;
    localparam int EVT_HALF  = PHASE_COUNT / 2;
    localparam int EVT_INIT  = (PHASE_COUNT > EVT_MAX) ? EVT_MAX : PHASE_COUNT;

    typedef struct packed {
        logic [PTR_W-1:0] ptr;
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic             hit;
        logic [MAG_W-1:0] mag;
        logic             sym;
    } evt_t;

    typedef struct packed {
        logic               clear;
        logic               take;
        logic [PHASE_W-1:0] idx;
        slot_t              word;
    } scan_req_t;

    function automatic logic [3:0] phase_field(input logic [PHASE_W-1:0] slot);
        logic [PHASE_W+3:0] ext;
        ext = {4'b0000, slot};
        return ext[3:0];
    endfunction

endpackage

@@ design/rdsst_ram.sv @@
module rdsst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/rdsst_event.sv @@
module rdsst_event
    import rdsst_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic signed [SAMPLE_W-1:0] rds,
    input  logic signed [SAMPLE_W-1:0] re,
    input  logic signed [SAMPLE_W-1:0] im,
    output evt_t                       evt
);

    logic signed [SAMPLE_W-1:0] last_rds_reg;
    logic signed [SAMPLE_W-1:0] last_re_reg;
    logic signed [SAMPLE_W-1:0] last_im_reg;
    logic signed [1:0]          last_rs_reg;
    logic signed [1:0]          last_is_reg;

    logic signed [1:0]          rs;
    logic signed [1:0]          is_;
    logic signed [2:0]          rsum;
    logic signed [2:0]          isum;
    logic [MAG_W-1:0]           close_cur;
    logic [MAG_W-1:0]           close_last;
    logic signed [SAMPLE_W-1:0] chosen;

    function automatic logic signed [1:0] sgn(input logic signed [SAMPLE_W-1:0] v);
        logic signed [1:0] s;
        if (v == '0)
        begin
            s = 2'sd0;
        end
        else if (v[SAMPLE_W-1])
        begin
            s = -2'sd1;
        end
        else
        begin
            s = 2'sd1;
        end
        return s;
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W:0] w;
        logic signed [SAMPLE_W:0] n;
        w = {v[SAMPLE_W-1], v};
        n = -w;
        return v[SAMPLE_W-1] ? n[MAG_W-1:0] : w[MAG_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] closeness(input logic signed [SAMPLE_W-1:0] a,
                                                   input logic signed [SAMPLE_W-1:0] b);
        logic [MAG_W-1:0] ma;
        logic [MAG_W-1:0] mb;
        ma = mag(a);
        mb = mag(b);
        return (ma < mb) ? ma : mb;
    endfunction

    always_comb
    begin
        rs         = sgn(re);
        is_        = sgn(im);
        rsum       = {last_rs_reg[1], last_rs_reg} + {rs[1], rs};
        isum       = {last_is_reg[1], last_is_reg} + {is_[1], is_};
        close_cur  = closeness(re, im);
        close_last = closeness(last_re_reg, last_im_reg);
        chosen     = (close_cur < close_last) ? rds : last_rds_reg;
        evt.hit    = (rsum == 3'sd0) || (isum == 3'sd0) || (rs == 2'sd0) || (is_ == 2'sd0);
        evt.mag    = mag(chosen);
        evt.sym    = !chosen[SAMPLE_W-1] && (chosen != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rds_reg <= '0;
            last_re_reg  <= '0;
            last_im_reg  <= '0;
            last_rs_reg  <= '0;
            last_is_reg  <= '0;
        end
        else if (take)
        begin
            last_rds_reg <= rds;
            last_re_reg  <= re;
            last_im_reg  <= im;
            last_rs_reg  <= rs;
            last_is_reg  <= is_;
        end
    end

endmodule

@@ design/rdsst_best.sv @@
module rdsst_best
    import rdsst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scan_req_t          req,
    output logic [PHASE_W-1:0] best_idx
);

    logic [SUM_W-1:0]   best_sum_reg;
    logic [CNT_W-1:0]   best_cnt_reg;
    logic [PHASE_W-1:0] best_idx_reg;
    logic [PROD_W-1:0]  lhs;
    logic [PROD_W-1:0]  rhs;
    logic               better;

    // exact average compare by cross-multiplication
    always_comb
    begin
        lhs    = PROD_W'(req.word.sum) * PROD_W'(best_cnt_reg);
        rhs    = PROD_W'(best_sum_reg) * PROD_W'(req.word.cnt);
        better = req.take && (req.word.cnt != '0) && (lhs > rhs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg <= '0;
            best_cnt_reg <= CNT_W'(1);
            best_idx_reg <= '0;
        end
        else if (req.clear)
        begin
            best_sum_reg <= '0;
            best_cnt_reg <= CNT_W'(1);
            best_idx_reg <= '0;
        end
        else if (better)
        begin
            best_sum_reg <= req.word.sum;
            best_cnt_reg <= req.word.cnt;
            best_idx_reg <= req.idx;
        end
    end

    assign best_idx = best_idx_reg;

endmodule

@@ design/rds_symbol_timing_bit_decoder_core.sv @@
// RDS biphase symbol timing recovery with differential bit decoding. One request on the
// input stream carries an RDS sample and a complex PLL sample; a request that is no
// timing event leaves the block idle, an event passes through a per-slot memory read,
// a history memory read, write-back and output hand-over plus any wait for the output
// register to drain, and the event that closes a round of phase slots adds a scan
// in which the per-slot memory is read back one slot a cycle to choose the best phase.
// The magnitude windows live in a PHASE_COUNT x WINDOW_DEPTH history memory; no
// clearing pass is needed after reset, the block is ready at once.
module rds_symbol_timing_bit_decoder_core
    import rdsst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // rds_sample, pll_real, pll_imag
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // decoded_bit, phase_used
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SLOT = 6'b000010,
        ST_HIST = 6'b000100,
        ST_EMIT = 6'b001000,
        ST_SCAN = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t             state_reg;
    state_t             state_next;

    evt_t               evt;
    evt_t               evt_reg;
    slot_t              slot_word_reg;
    logic               fire_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] best_phase_reg;
    logic [EVT_W-1:0]   events_reg;
    logic               last_sym_reg;
    logic [SCAN_W-1:0]  scan_cnt_reg;
    logic [PHASE_COUNT-1:0] slot_vld_reg;
    logic [PHASE_W-1:0] slot_ridx_reg;

    logic               out_valid_reg;
    logic               out_bit_reg;
    logic [3:0]         out_phase_reg;

    logic               accept;
    logic               out_free;
    logic               advance;

    logic [PHASE_W-1:0] slot_raddr;
    logic [SLOT_W-1:0]  slot_rdata;
    slot_t              slot_rd;
    slot_t              slot_upd;
    logic               slot_we;

    logic [HIST_AW-1:0] hist_raddr;
    logic [HIST_AW-1:0] hist_waddr;
    logic [MAG_W-1:0]   hist_rdata;
    logic               hist_we;
    logic               full;

    scan_req_t          scan_req;
    logic [PHASE_W-1:0] scan_best;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = !fire_reg || out_free;

    rdsst_event u_event (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (accept),
        .rds   (s_axis_tdata[15:0]),
        .re    (s_axis_tdata[31:16]),
        .im    (s_axis_tdata[47:32]),
        .evt   (evt)
    );

    // per-slot sums, fill counts and pointers
    rdsst_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (PHASE_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (phase_reg),
        .wdata (slot_upd),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    rdsst_ram #(
        .WIDTH (MAG_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (evt_reg.mag),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    rdsst_best u_best (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (scan_req),
        .best_idx (scan_best)
    );

    always_comb
    begin
        slot_raddr = (state_reg == ST_SCAN) ? scan_cnt_reg[PHASE_W-1:0] : phase_reg;
        // a slot never written reads as empty
        slot_rd    = slot_vld_reg[slot_ridx_reg] ? slot_t'(slot_rdata) : '0;
        hist_raddr = {phase_reg, slot_rd.ptr};
        hist_waddr = {phase_reg, slot_word_reg.ptr};
        full       = (slot_word_reg.cnt >= CNT_W'(WINDOW_DEPTH));

        slot_upd.sum = slot_word_reg.sum - (full ? SUM_W'(hist_rdata) : '0)
                       + SUM_W'(evt_reg.mag);
        slot_upd.cnt = full ? slot_word_reg.cnt : slot_word_reg.cnt + CNT_W'(1);
        slot_upd.ptr = (slot_word_reg.ptr == PTR_W'(WINDOW_DEPTH - 1)) ?
                       '0 : slot_word_reg.ptr + PTR_W'(1);

        slot_we = (state_reg == ST_HIST);
        hist_we = (state_reg == ST_HIST);

        scan_req.clear = (state_reg == ST_EMIT) && advance
                         && (phase_reg == PHASE_W'(PHASE_COUNT - 1));
        scan_req.take  = (state_reg == ST_SCAN) && (scan_cnt_reg != '0);
        scan_req.idx   = slot_ridx_reg;
        scan_req.word  = slot_rd;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && evt.hit)
                begin
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                state_next = ST_HIST;
            end
            ST_HIST:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (advance)
                begin
                    state_next = scan_req.clear ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == SCAN_W'(PHASE_COUNT))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= '0;
            best_phase_reg <= '0;
            events_reg     <= EVT_W'(EVT_INIT);
            last_sym_reg   <= 1'b0;
            scan_cnt_reg   <= '0;
            slot_vld_reg   <= '0;
            slot_ridx_reg  <= '0;
            fire_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_ridx_reg <= slot_raddr;

            if ((state_reg == ST_EMIT) && advance && fire_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == ST_HIST)
            begin
                slot_vld_reg[phase_reg] <= 1'b1;
                fire_reg <= (best_phase_reg == phase_reg) && (events_reg > EVT_W'(EVT_HALF));
            end

            if ((state_reg == ST_EMIT) && advance)
            begin
                if (fire_reg)
                begin
                    last_sym_reg  <= evt_reg.sym;
                    events_reg    <= EVT_W'(1);
                end
                else if (events_reg != EVT_W'(EVT_MAX))
                begin
                    events_reg <= events_reg + EVT_W'(1);
                end
                if (scan_req.clear)
                begin
                    phase_reg    <= '0;
                    scan_cnt_reg <= '0;
                end
                else
                begin
                    phase_reg <= phase_reg + PHASE_W'(1);
                end
            end

            if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
            end

            if (state_reg == ST_DONE)
            begin
                best_phase_reg <= scan_best;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            evt_reg <= evt;
        end
        if (state_reg == ST_SLOT)
        begin
            slot_word_reg <= slot_rd;
        end
        if ((state_reg == ST_EMIT) && fire_reg && out_free)
        begin
            out_bit_reg   <= last_sym_reg ^ evt_reg.sym;
            out_phase_reg <= phase_field(phase_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_phase_reg, out_bit_reg};

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import rdsst_pkg::*;

    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic       decoded_bit;
        logic [3:0] phase_used;
    } bit_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    // predictor state
    int unsigned     mag_window [PHASE_COUNT][WINDOW_DEPTH];
    longint unsigned mag_sum [PHASE_COUNT];
    int unsigned     fill_count [PHASE_COUNT];
    int unsigned     write_ptr [PHASE_COUNT];
    int              prev_rds = 0;
    int              prev_re = 0;
    int              prev_im = 0;
    int              prev_re_sign = 0;
    int              prev_im_sign = 0;
    logic            prev_symbol = 1'b0;
    int unsigned     slot_counter = 0;
    int unsigned     since_output = PHASE_COUNT;
    int unsigned     best_slot = 0;
    bit_result_t     pending_bits [$];

    bit          idle_on = 1'b1;
    bit          hold_output = 1'b0;
    int unsigned fav_slot = 5;
    int          quadrant = 0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    rds_symbol_timing_bit_decoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rds_symbol_timing_bit_decoder_core test failed");
            $finish;
        end
    end

    function automatic int sign_of(int v);
        if (v > 0)
            return 1;
        if (v < 0)
            return -1;
        return 0;
    endfunction

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int closeness(int re, int im);
        return (magnitude(re) < magnitude(im)) ? magnitude(re) : magnitude(im);
    endfunction

    function automatic void predict_bit_decode(int rds, int re, int im);
        int              sr;
        int              si;
        int              chosen;
        int unsigned     slot;
        longint unsigned top_sum;
        longint unsigned top_cnt;
        bit_result_t     res;
        sr = sign_of(re);
        si = sign_of(im);
        if (prev_re_sign + sr == 0 || prev_im_sign + si == 0 || sr == 0 || si == 0)
        begin
            // ties in closeness keep the previous sample
            chosen = (closeness(re, im) < closeness(prev_re, prev_im)) ? rds : prev_rds;
            slot = slot_counter;
            if (fill_count[slot] >= WINDOW_DEPTH)
                mag_sum[slot] -= mag_window[slot][write_ptr[slot]];
            else
                fill_count[slot]++;
            mag_window[slot][write_ptr[slot]] = magnitude(chosen);
            mag_sum[slot] += magnitude(chosen);
            write_ptr[slot] = (write_ptr[slot] + 1) % WINDOW_DEPTH;
            if (best_slot == slot && since_output > PHASE_COUNT / 2)
            begin
                res.decoded_bit = prev_symbol ^ (chosen > 0);
                res.phase_used = 4'(slot);
                prev_symbol = (chosen > 0);
                since_output = 0;
                pending_bits.push_back(res);
            end
            if (since_output < 255)
                since_output++;
            slot_counter = slot + 1;
            if (slot_counter >= PHASE_COUNT)
            begin
                // strictly highest average by cross-multiplication, lowest slot on ties
                slot_counter = 0;
                best_slot = 0;
                top_sum = 0;
                top_cnt = 1;
                for (int i = 0; i < PHASE_COUNT; i++)
                begin
                    if (fill_count[i] != 0 && mag_sum[i] * top_cnt > top_sum * fill_count[i])
                    begin
                        top_sum = mag_sum[i];
                        top_cnt = fill_count[i];
                        best_slot = i;
                    end
                end
            end
        end
        prev_rds = rds;
        prev_re = re;
        prev_im = im;
        prev_re_sign = sr;
        prev_im_sign = si;
    endfunction

    function automatic void note_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    always @(posedge clk)
    begin
        bit_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_bits.size() == 0)
                note_mismatch("result with none pending, data", 0, m_axis_tdata);
            else
            begin
                want = pending_bits.pop_front();
                if (m_axis_tdata[0] !== want.decoded_bit)
                    note_mismatch("decoded_bit", want.decoded_bit, m_axis_tdata[0]);
                if (m_axis_tdata[4:1] !== want.phase_used)
                    note_mismatch("phase_used", want.phase_used, m_axis_tdata[4:1]);
                if (m_axis_tdata[7:5] !== 3'b000)
                    note_mismatch("padding", 0, m_axis_tdata[7:5]);
            end
        end
    end

    // result side: random stalls and one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                hold_output = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_sample(input logic signed [15:0] rds, re, im);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re, rds};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_bit_decode(rds, re, im);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_bits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // larger magnitudes on one favoured slot so the best phase moves around
    function automatic logic signed [15:0] pick_rds();
        if (slot_counter == fav_slot && $urandom_range(0, 3) != 0)
            return $urandom_range(0, 1) ? 16'(32'h8000 + $urandom_range(0, 8191))
                                        : 16'(32'h7FFF - $urandom_range(0, 8191));
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        // first round all zero: every average zero, slot zero stays best
        send_sample(16'sd0, 16'sd0, 16'sd0);
        for (int i = 1; i <= 16; i++)
            send_sample(16'sd0, (i % 2) ? 16'sh8000 : 16'sh7FFF,
                        (i % 3 == 0) ? 16'sd0 : 16'sh8000);
        // no sign change, no zero
        send_sample(16'sh7FFF, 16'sd100, -16'sd100);
        // equal closeness
        send_sample(16'sh8000, -16'sd100, 16'sd100);
        send_sample(16'sh8000, 16'sd5, -16'sd7);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_sample(-16'sd1, 16'sh7FFF, 16'sh8000);
        send_sample(16'sd1, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sd0, 16'sd1, 16'sd1);
    endtask

    task automatic test_window_wrap();
        logic signed [15:0] re;
        bit                 re_pos;
        re_pos = 1'b1;
        repeat (PHASE_COUNT * (WINDOW_DEPTH + 12))
        begin
            re = 16'($urandom_range(1, 32767));
            if (!re_pos)
                re = -re;
            re_pos = !re_pos;
            if ($urandom_range(0, 299) == 0)
                fav_slot = $urandom_range(0, PHASE_COUNT - 1);
            send_sample(pick_rds(), re, 16'($urandom_range(1, 32767)));
        end
    endtask

    task automatic test_backpressure();
        logic signed [15:0] re;
        hold_output = 1'b1;
        re = 16'sd3000;
        repeat (3 * PHASE_COUNT)
        begin
            re = -re;
            send_sample(pick_rds(), re, 16'sd500);
        end
        wait_for_results();
    endtask

    task automatic test_random_stream(input int count);
        logic signed [15:0] re;
        logic signed [15:0] im;
        int                 kind;
        repeat (count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                // rotating reference with random amplitude
                if ($urandom_range(0, 9) < 6)
                    quadrant = (quadrant + 1) % 4;
                re = 16'($urandom_range(1, 32767));
                im = 16'($urandom_range(1, 32767));
                if (quadrant == 1 || quadrant == 2)
                    re = -re;
                if (quadrant >= 2)
                    im = -im;
            end
            else if (kind == 7)
            begin
                re = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom);
                im = (re == 0) ? 16'($urandom) : 16'sd0;
            end
            else
            begin
                re = 16'($urandom);
                im = 16'($urandom);
            end
            if ($urandom_range(0, 199) == 0)
                fav_slot = $urandom_range(0, PHASE_COUNT - 1);
            send_sample(pick_rds(), re, im);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_window_wrap();
        test_backpressure();
        test_random_stream(800);
        idle_on = 1'b0;
        test_random_stream(200);
        wait_for_results();
        if (mismatches == 0 && pending_bits.size() == 0)
            $display("rds_symbol_timing_bit_decoder_core test passed");
        else
            $display("rds_symbol_timing_bit_decoder_core test failed");
        $finish;
    end

endmodule
